// File: design/atsc_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package atsc_pkg;

    localparam int unsigned SAMPLE_W = 13;
    localparam int unsigned SUM_W    = 15;
    localparam int unsigned MAG_W    = 14;
    localparam int unsigned LIMIT_W  = 13;
    localparam int unsigned COUNT_W  = 20;
    localparam int unsigned PHASE_W  = 11;
    localparam int unsigned CFG_IDX_W = 2;
    localparam int unsigned CFG_DAT_W = 20;

    // floor(x * 21846 / 2^16) equals floor(x / 3) for x up to 3 * 4096
    localparam logic [15:0] RECIP3     = 16'd21846;
    localparam logic [LIMIT_W-1:0]  EXCESS_LIMIT  = 13'd200;
    localparam logic [LIMIT_W-1:0]  YZ_LIMIT_STEP = 13'd2;
    localparam logic [LIMIT_W-1:0]  LIMIT_CEIL    = 13'd8191;
    localparam logic [LIMIT_W-1:0]  LIMIT_RESET   = 13'd205;
    localparam logic [PHASE_W-1:0]  PHASE_LAST    = 11'd1999;
    localparam logic [COUNT_W-1:0]  GOAL_TOTAL    = 20'd10000;
    localparam logic [COUNT_W-1:0]  COUNT_MAX     = 20'hFFFFF;

    localparam logic [CFG_IDX_W-1:0] CFG_X_THR   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_YZ_MIN  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_YZ_MAX  = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_RECORD  = 2'd3;

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] avg;
        logic signed [SAMPLE_W-1:0] first;
    } t_lane_out;

    // abs(|cur| - |last|)
    function automatic logic [LIMIT_W-1:0] change_of(
        input logic signed [SAMPLE_W-1:0] cur,
        input logic signed [SAMPLE_W-1:0] last
    );
        logic [SAMPLE_W-1:0] a_cur;
        logic [SAMPLE_W-1:0] a_last;
        logic signed [SAMPLE_W:0] diff;
        a_cur  = cur[SAMPLE_W-1] ? SAMPLE_W'(-cur) : SAMPLE_W'(cur);
        a_last = last[SAMPLE_W-1] ? SAMPLE_W'(-last) : SAMPLE_W'(last);
        diff   = $signed({1'b0, a_cur}) - $signed({1'b0, a_last});
        change_of = diff[SAMPLE_W] ? LIMIT_W'(-diff) : LIMIT_W'(diff);
    endfunction

endpackage
`default_nettype wire

// File: design/accel_threshold_step_counter_unit.sv
// Threshold step counter: each input transaction carries three samples per axis. Three
// axis lanes average their samples (truncated toward zero) in a first register stage, then
// a merge stage compares the changes against the baseline, adapts the y/z thresholds and,
// on a batch_end transaction, counts at most one step and loads one result into the output
// register. One transaction is accepted every cycle while o_ready is high; a result
// passes through the lane register, then the output register, and can be held between.
// Only a batch_end transaction arriving while an earlier result still waits untaken
// holds the input, since the output register is the single result slot. Configuration
// is written on i_cfg_we/i_cfg_index/i_cfg_data while idle, which only the user ensures.
`timescale 1ns / 1ps
`default_nettype none
module accel_threshold_step_counter_unit
    import atsc_pkg::*;
(
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0]       i_cfg_index,
    input  wire logic [CFG_DAT_W-1:0]       i_cfg_data,
    input  wire logic                       i_valid,
    output logic                            o_ready,
    input  wire logic signed [SAMPLE_W-1:0] i_sample_x0,
    input  wire logic signed [SAMPLE_W-1:0] i_sample_x1,
    input  wire logic signed [SAMPLE_W-1:0] i_sample_x2,
    input  wire logic signed [SAMPLE_W-1:0] i_sample_y0,
    input  wire logic signed [SAMPLE_W-1:0] i_sample_y1,
    input  wire logic signed [SAMPLE_W-1:0] i_sample_y2,
    input  wire logic signed [SAMPLE_W-1:0] i_sample_z0,
    input  wire logic signed [SAMPLE_W-1:0] i_sample_z1,
    input  wire logic signed [SAMPLE_W-1:0] i_sample_z2,
    input  wire logic                       i_vibrating,
    input  wire logic                       i_batch_end,
    output logic                            o_valid,
    input  wire logic                       i_ready,
    output logic [COUNT_W-1:0]              o_step_total,
    output logic                            o_step_taken,
    output logic                            o_milestone,
    output logic                            o_goal_reached,
    output logic                            o_new_record
);

    logic      load;
    t_lane_out lane_x, lane_y, lane_z;

    atsc_lane u_lane_x (
        .i_clk  (i_clk),
        .i_load (load),
        .i_s0   (i_sample_x0),
        .i_s1   (i_sample_x1),
        .i_s2   (i_sample_x2),
        .o_lane (lane_x)
    );

    atsc_lane u_lane_y (
        .i_clk  (i_clk),
        .i_load (load),
        .i_s0   (i_sample_y0),
        .i_s1   (i_sample_y1),
        .i_s2   (i_sample_y2),
        .o_lane (lane_y)
    );

    atsc_lane u_lane_z (
        .i_clk  (i_clk),
        .i_load (load),
        .i_s0   (i_sample_z0),
        .i_s1   (i_sample_z1),
        .i_s2   (i_sample_z2),
        .o_lane (lane_z)
    );

    atsc_core u_core (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data),
        .i_valid        (i_valid),
        .o_ready        (o_ready),
        .i_vibrating    (i_vibrating),
        .i_batch_end    (i_batch_end),
        .o_load         (load),
        .i_lane_x       (lane_x),
        .i_lane_y       (lane_y),
        .i_lane_z       (lane_z),
        .o_valid        (o_valid),
        .i_ready        (i_ready),
        .o_step_total   (o_step_total),
        .o_step_taken   (o_step_taken),
        .o_milestone    (o_milestone),
        .o_goal_reached (o_goal_reached),
        .o_new_record   (o_new_record)
    );

endmodule
`default_nettype wire

// File: design/atsc_lane.sv
`timescale 1ns / 1ps
`default_nettype none
module atsc_lane
    import atsc_pkg::*;
(
    input  wire logic                       i_clk,
    input  wire logic                       i_load,
    input  wire logic signed [SAMPLE_W-1:0] i_s0,
    input  wire logic signed [SAMPLE_W-1:0] i_s1,
    input  wire logic signed [SAMPLE_W-1:0] i_s2,
    output t_lane_out                       o_lane
);

    logic signed [SUM_W-1:0]    sum;
    logic [MAG_W-1:0]           mag;
    logic [29:0]                prod;
    logic [SAMPLE_W-1:0]        quot;
    logic signed [SAMPLE_W-1:0] n_avg;
    t_lane_out                  r_lane;

    always_comb begin
        sum  = SUM_W'(i_s0) + SUM_W'(i_s1) + SUM_W'(i_s2);
        mag  = sum[SUM_W-1] ? MAG_W'(-sum) : MAG_W'(sum);
        prod = 30'(mag) * 30'(RECIP3);
        quot = prod[28:16];
        // truncation toward zero: divide the magnitude, then restore the sign
        n_avg = sum[SUM_W-1] ? $signed(SAMPLE_W'(-quot)) : $signed(quot);
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_lane.avg   <= n_avg;
            r_lane.first <= i_s0;
        end
    end

    assign o_lane = r_lane;

endmodule
`default_nettype wire

// File: design/atsc_core.sv
`timescale 1ns / 1ps
`default_nettype none
module atsc_core
    import atsc_pkg::*;
(
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [CFG_DAT_W-1:0]  i_cfg_data,
    input  wire logic                  i_valid,
    output logic                       o_ready,
    input  wire logic                  i_vibrating,
    input  wire logic                  i_batch_end,
    output logic                       o_load,
    input  wire t_lane_out             i_lane_x,
    input  wire t_lane_out             i_lane_y,
    input  wire t_lane_out             i_lane_z,
    output logic                       o_valid,
    input  wire logic                  i_ready,
    output logic [COUNT_W-1:0]         o_step_total,
    output logic                       o_step_taken,
    output logic                       o_milestone,
    output logic                       o_goal_reached,
    output logic                       o_new_record
);

    logic [LIMIT_W-1:0] r_x_thr, r_yz_min, r_yz_max;
    logic [COUNT_W-1:0] r_record;

    logic r_s1_valid, r_s1_vib, r_s1_batch;
    logic s1_fire;

    logic signed [SAMPLE_W-1:0] r_base_x, r_base_y, r_base_z;
    logic signed [SAMPLE_W-1:0] r_avg_x, r_avg_y, r_avg_z;
    logic signed [SAMPLE_W-1:0] n_avg_x, n_avg_y, n_avg_z;
    logic [2:0]         r_hits, n_hits;
    logic               r_started;
    logic [LIMIT_W-1:0] r_y_limit, r_z_limit, n_y_limit, n_z_limit;
    logic [COUNT_W-1:0] r_count, n_count;
    logic [PHASE_W-1:0] r_phase, n_phase;
    logic               r_armed, n_armed;
    logic               qualify, bumped, rec_hit, mile_hit, goal_hit;
    logic [COUNT_W-1:0] count_inc;

    logic               r_o_valid, r_o_taken, r_o_mile, r_o_goal, r_o_rec;
    logic [COUNT_W-1:0] r_o_total;

    logic [LIMIT_W-1:0] dx, dy, dz;
    logic               hy, hz;

    function automatic logic [LIMIT_W-1:0] adapt(
        input logic [LIMIT_W-1:0] delta,
        input logic [LIMIT_W-1:0] limit,
        input logic [LIMIT_W-1:0] lo,
        input logic [LIMIT_W-1:0] hi
    );
        logic [LIMIT_W-1:0] l;
        logic [LIMIT_W:0]   raised;
        l = limit;
        adapt = limit;
        if (delta >= limit && (delta - limit) > EXCESS_LIMIT) begin
            if (l > hi) begin
                l = hi;
            end else if (l < lo) begin
                l = lo;
            end
            if (l < hi) begin
                raised = {1'b0, l} + {1'b0, YZ_LIMIT_STEP};
                l = raised[LIMIT_W] ? LIMIT_CEIL : raised[LIMIT_W-1:0];
            end
            adapt = l;
        end
    endfunction

    // a batch transaction needs the output register free
    assign s1_fire = r_s1_valid && !(r_s1_batch && r_o_valid && !i_ready);
    assign o_ready = !r_s1_valid || s1_fire;
    assign o_load  = i_valid && o_ready;

    always_comb begin
        dx = change_of(i_lane_x.avg, r_base_x);
        dy = change_of(i_lane_y.avg, r_base_y);
        dz = change_of(i_lane_z.avg, r_base_z);
        hy = dy >= r_y_limit;
        hz = dz >= r_z_limit;

        n_avg_x   = r_avg_x;
        n_avg_y   = r_avg_y;
        n_avg_z   = r_avg_z;
        n_hits    = r_hits;
        n_y_limit = r_y_limit;
        n_z_limit = r_z_limit;
        if (r_started) begin
            n_avg_x   = i_lane_x.avg;
            n_avg_y   = i_lane_y.avg;
            n_avg_z   = i_lane_z.avg;
            n_hits    = r_hits | {hz, hy, dx >= r_x_thr};
            n_y_limit = adapt(dy, r_y_limit, r_yz_min, r_yz_max);
            n_z_limit = adapt(dz, r_z_limit, r_yz_min, r_yz_max);
        end

        qualify   = n_hits[0] && (n_hits[1] || n_hits[2]) && !r_s1_vib;
        bumped    = qualify && (r_count != COUNT_MAX);
        count_inc = r_count + COUNT_W'(1);
        n_count   = bumped ? count_inc : r_count;
        n_phase   = r_phase;
        if (bumped) begin
            n_phase = (r_phase == PHASE_LAST) ? '0 : r_phase + PHASE_W'(1);
        end
        rec_hit  = bumped && r_armed && (r_record != '0) && (count_inc > r_record);
        n_armed  = r_armed && !rec_hit;
        mile_hit = bumped && (r_phase == PHASE_LAST);
        goal_hit = mile_hit && (count_inc >= GOAL_TOTAL);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_x_thr  <= 13'd75;
            r_yz_min <= 13'd175;
            r_yz_max <= 13'd205;
            r_record <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_X_THR:  r_x_thr  <= i_cfg_data[LIMIT_W-1:0];
                CFG_YZ_MIN: r_yz_min <= i_cfg_data[LIMIT_W-1:0];
                CFG_YZ_MAX: r_yz_max <= i_cfg_data[LIMIT_W-1:0];
                CFG_RECORD: r_record <= i_cfg_data[COUNT_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (o_ready) begin
            r_s1_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_load) begin
            r_s1_vib   <= i_vibrating;
            r_s1_batch <= i_batch_end;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_base_x  <= '0;
            r_base_y  <= '0;
            r_base_z  <= '0;
            r_avg_x   <= '0;
            r_avg_y   <= '0;
            r_avg_z   <= '0;
            r_hits    <= '0;
            r_started <= 1'b0;
            r_y_limit <= LIMIT_RESET;
            r_z_limit <= LIMIT_RESET;
            r_count   <= '0;
            r_phase   <= '0;
            r_armed   <= 1'b1;
        end else if (s1_fire) begin
            r_avg_x   <= n_avg_x;
            r_avg_y   <= n_avg_y;
            r_avg_z   <= n_avg_z;
            r_y_limit <= n_y_limit;
            r_z_limit <= n_z_limit;
            r_started <= 1'b1;
            if (r_s1_batch) begin
                r_base_x <= n_avg_x;
                r_base_y <= n_avg_y;
                r_base_z <= n_avg_z;
                r_hits   <= '0;
                r_count  <= n_count;
                r_phase  <= n_phase;
                r_armed  <= n_armed;
            end else begin
                r_hits <= n_hits;
                if (!r_started) begin
                    r_base_x <= i_lane_x.first;
                    r_base_y <= i_lane_y.first;
                    r_base_z <= i_lane_z.first;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else if (s1_fire && r_s1_batch) begin
            r_o_valid <= 1'b1;
        end else if (i_ready) begin
            r_o_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_fire && r_s1_batch) begin
            r_o_total <= n_count;
            r_o_taken <= qualify;
            r_o_mile  <= mile_hit;
            r_o_goal  <= goal_hit;
            r_o_rec   <= rec_hit;
        end
    end

    assign o_valid        = r_o_valid;
    assign o_step_total   = r_o_total;
    assign o_step_taken   = r_o_taken;
    assign o_milestone    = r_o_mile;
    assign o_goal_reached = r_o_goal;
    assign o_new_record   = r_o_rec;

    a_phase_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_phase <= PHASE_LAST)
        else $error("milestone phase out of range");

    a_flags_need_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_o_valid && !r_o_taken |-> !r_o_mile && !r_o_goal && !r_o_rec)
        else $error("flag raised without a counted step");

    a_goal_is_mile: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_o_valid && r_o_goal |-> r_o_mile && r_phase == '0)
        else $error("goal flag without milestone");

    a_record_once: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $fell(r_armed) |-> r_o_valid && r_o_rec)
        else $error("record disarmed without reporting");

    a_batch_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_o_valid && !i_ready && r_s1_valid && r_s1_batch |=> r_s1_valid)
        else $error("batch transaction dropped while output stalled");

endmodule
`default_nettype wire
